// File: sv/tli_pkg.sv
// Shared types and constants of the table linear interpolator.
package tli_pkg;

  localparam int unsigned XW = 32;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_EXACT  = 3'd1,
    ST_BELOW  = 3'd2,
    ST_ABOVE  = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_MUL,
    S_DIVGO,
    S_DIV
  } state_e;

endpackage

// File: sv/tli_div.sv
// Iterative restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
module tli_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [2*tli_pkg::XW-1:0]     dividend_i,
  input  logic [tli_pkg::XW-1:0]       divisor_i,
  output logic                         done_o,
  output logic [tli_pkg::XW-1:0]       quotient_o
);

  localparam int unsigned XW = tli_pkg::XW;
  localparam int unsigned SW = $clog2(XW);

  logic          run_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [XW-1:0] rem_q;
  logic [XW-1:0] quo_q;
  logic [XW-1:0] dvs_q;
  logic [XW:0]   trial;
  logic          fit;

  // Dividend high half is known to be below the divisor, so the quotient fits XW bits.
  assign trial = {rem_q, quo_q[XW-1]};
  assign fit   = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(XW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[2*XW-1:XW];
      quo_q <= dividend_i[XW-1:0];
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fit ? XW'(trial - {1'b0, dvs_q}) : trial[XW-1:0];
      quo_q <= {quo_q[XW-2:0], fit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: sv/table_linear_interpolator.sv
// Top level of the piecewise linear table interpolator.
//
// Requests enter on start while busy is low. func_i = 0 loads a point
// (key_x_i, point_value_i) into the table; restart_i = 1 empties the table
// first. A load completes at the edge it is taken, gives no result and
// leaves busy low, so a request may follow in the next cycle. Loads past
// DEPTH points are dropped.
// func_i = 1 queries the table at key_x_i. The block scans the N stored
// points one per cycle from its point memory, then forms the bracket
// difference product on one multiplier and divides it on a one-bit-per-cycle
// divider. The table scan and the 32-step divider set the query time.
// Below-range, above-range and exact-hit queries end after the scan and
// skip the divider; a query of an empty table answers in the next cycle
// with busy left low. Otherwise busy stays high for the whole query.
// Each result shows on result_value_o and status_o for one cycle with done_o
// high; the receiver cannot stall it, and busy is low in that same cycle.
// Reset empties the table; the point memory itself is not cleared.
module table_linear_interpolator #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        func_i,
  input  logic                        restart_i,
  input  logic signed [31:0]          key_x_i,
  input  logic signed [31:0]          point_value_i,
  output logic                        done_o,
  output logic signed [31:0]          result_value_o,
  output logic [2:0]                  status_o
);

  localparam int unsigned XW    = tli_pkg::XW;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tli_pkg::state_e state_q, state_d;

  logic [2*XW-1:0] pt_mem [DEPTH];
  logic [2*XW-1:0] rd_q;
  logic            rvld_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] idx_q;

  logic signed [XW-1:0] xq_q;
  logic signed [XW-1:0] lo_x_q, hi_x_q;
  logic signed [XW-1:0] lo_y_q, hi_y_q;
  logic                 lo_vld_q, hi_vld_q;

  logic [XW-1:0]   dx_q, span_q, mag_q;
  logic            neg_q;
  logic [2*XW-1:0] prod_q;

  logic                 done_q;
  logic signed [XW-1:0] res_q;
  tli_pkg::status_e     status_q;

  logic            take;
  logic            load_req;
  logic            query_req;
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic            rd_en;
  logic            div_start;
  logic            div_done;
  logic [XW-1:0]   div_quo;
  logic signed [XW-1:0] xi, yi;

  assign take      = start && !busy;
  assign load_req  = take && !func_i;
  assign query_req = take && func_i;
  assign wr_en     = load_req && (restart_i || (cnt_q < CNT_W'(DEPTH)));
  assign wr_addr   = restart_i ? '0 : cnt_q[IDX_W-1:0];
  assign rd_en     = (state_q == tli_pkg::S_SCAN) && (idx_q < cnt_q);
  assign div_start = (state_q == tli_pkg::S_DIVGO);
  assign xi        = $signed(rd_q[2*XW-1:XW]);
  assign yi        = $signed(rd_q[XW-1:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pt_mem[wr_addr] <= {key_x_i, point_value_i};
    end
    if (rd_en) begin
      rd_q <= pt_mem[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tli_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tli_pkg::S_IDLE: begin
        if (query_req && (cnt_q != '0)) begin
          state_d = tli_pkg::S_SCAN;
        end
      end
      tli_pkg::S_SCAN: begin
        if (!rd_en && !rvld_q) begin
          state_d = tli_pkg::S_EVAL;
        end
      end
      tli_pkg::S_EVAL: begin
        if (lo_vld_q && hi_vld_q && (lo_x_q != xq_q)) begin
          state_d = tli_pkg::S_MUL;
        end else begin
          state_d = tli_pkg::S_IDLE;
        end
      end
      tli_pkg::S_MUL:   state_d = tli_pkg::S_DIVGO;
      tli_pkg::S_DIVGO: state_d = tli_pkg::S_DIV;
      tli_pkg::S_DIV: begin
        if (div_done) begin
          state_d = tli_pkg::S_IDLE;
        end
      end
      default: state_d = tli_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_q != tli_pkg::S_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      rvld_q   <= 1'b0;
      lo_vld_q <= 1'b0;
      hi_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      rvld_q <= rd_en;
      done_q <= 1'b0;
      if (wr_en) begin
        cnt_q <= restart_i ? CNT_W'(1) : cnt_q + 1'b1;
      end
      if (query_req) begin
        idx_q    <= '0;
        lo_vld_q <= 1'b0;
        hi_vld_q <= 1'b0;
        done_q   <= (cnt_q == '0);
      end
      if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
      if (rvld_q) begin
        if ((xi <= xq_q) && (!lo_vld_q || (xi > lo_x_q))) begin
          lo_vld_q <= 1'b1;
        end
        if ((xi >= xq_q) && (!hi_vld_q || (xi < hi_x_q))) begin
          hi_vld_q <= 1'b1;
        end
      end
      if (state_q == tli_pkg::S_EVAL) begin
        done_q <= !(lo_vld_q && hi_vld_q && (lo_x_q != xq_q));
      end
      if ((state_q == tli_pkg::S_DIV) && div_done) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (query_req) begin
      xq_q     <= key_x_i;
      res_q    <= '0;
      status_q <= tli_pkg::ST_EMPTY;
    end
    if (rvld_q) begin
      if ((xi <= xq_q) && (!lo_vld_q || (xi > lo_x_q))) begin
        lo_x_q <= xi;
        lo_y_q <= yi;
      end
      if ((xi >= xq_q) && (!hi_vld_q || (xi < hi_x_q))) begin
        hi_x_q <= xi;
        hi_y_q <= yi;
      end
    end
    if (state_q == tli_pkg::S_EVAL) begin
      dx_q   <= XW'(xq_q - lo_x_q);
      span_q <= XW'(hi_x_q - lo_x_q);
      neg_q  <= (hi_y_q < lo_y_q);
      mag_q  <= (hi_y_q < lo_y_q) ? XW'(lo_y_q - hi_y_q) : XW'(hi_y_q - lo_y_q);
      if (!lo_vld_q) begin
        res_q    <= '0;
        status_q <= tli_pkg::ST_BELOW;
      end else if (!hi_vld_q) begin
        res_q    <= '0;
        status_q <= tli_pkg::ST_ABOVE;
      end else if (lo_x_q == xq_q) begin
        res_q    <= lo_y_q;
        status_q <= tli_pkg::ST_EXACT;
      end
    end
    if (state_q == tli_pkg::S_MUL) begin
      prod_q <= dx_q * mag_q;
    end
    if ((state_q == tli_pkg::S_DIV) && div_done) begin
      res_q    <= neg_q ? XW'(lo_y_q - $signed(div_quo)) : XW'(lo_y_q + $signed(div_quo));
      status_q <= tli_pkg::ST_INTERP;
    end
  end

  tli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the table linear interpolator.
`timescale 1ns / 1ps

module tb_top;

  localparam int TBL_DEPTH = 256;
  localparam int ITEMS = 650;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 320;
  localparam int PLAN_ROWS = 26;

  typedef struct packed {
    logic [31:0]      value;
    tli_pkg::status_e status;
  } answer_t;

  typedef struct packed {
    logic        is_query;
    logic        clear;
    logic [31:0] x;
    logic [31:0] y;
    logic        pinned;
    answer_t     want;
  } step_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               func_i;
  logic               restart_i;
  logic signed [31:0] key_x_i;
  logic signed [31:0] point_value_i;
  logic               done_o;
  logic signed [31:0] result_value_o;
  logic [2:0]         status_o;

  logic    pin_on;
  answer_t pin_answer;

  logic signed [31:0] pt_x [TBL_DEPTH];
  logic signed [31:0] pt_y [TBL_DEPTH];
  int                 pt_count;

  answer_t answers_due [$];
  int      n_taken;
  int      n_sent;
  int      n_fail;
  int      idle_cycles;

  table_linear_interpolator #(
    .DEPTH(TBL_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .restart_i      (restart_i),
    .key_x_i        (key_x_i),
    .point_value_i  (point_value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic answer_t predict_lookup(logic signed [31:0] xq);
    answer_t a;
    int lo;
    int hi;
    longint x1;
    longint x2;
    longint y1;
    longint y2;
    longint res;
    bit [63:0] dx;
    bit [63:0] span;
    bit [63:0] mag;
    bit [63:0] q;
    lo = -1;
    hi = -1;
    a.value = '0;
    a.status = tli_pkg::ST_EMPTY;
    if (pt_count == 0) return a;
    for (int i = 0; i < pt_count; i++) begin
      if (pt_x[i] <= xq && (lo < 0 || pt_x[i] > pt_x[lo])) lo = i;
      if (pt_x[i] >= xq && (hi < 0 || pt_x[i] < pt_x[hi])) hi = i;
    end
    if (lo < 0) begin
      a.status = tli_pkg::ST_BELOW;
      return a;
    end
    if (hi < 0) begin
      a.status = tli_pkg::ST_ABOVE;
      return a;
    end
    x1 = pt_x[lo];
    y1 = pt_y[lo];
    if (x1 == longint'(xq)) begin
      a.value = pt_y[lo];
      a.status = tli_pkg::ST_EXACT;
      return a;
    end
    x2 = pt_x[hi];
    y2 = pt_y[hi];
    dx = longint'(xq) - x1;
    span = x2 - x1;
    if (y2 >= y1) begin
      mag = y2 - y1;
      q = (dx * mag) / span;
      res = y1 + longint'(q);
    end else begin
      mag = y1 - y2;
      q = (dx * mag) / span;
      res = y1 - longint'(q);
    end
    a.value = res[31:0];
    a.status = tli_pkg::ST_INTERP;
    return a;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (answers_due.size() == 0) begin
          $error("unexpected result: result_value %h status %0d", result_value_o, status_o);
          n_fail++;
        end else begin
          want = answers_due.pop_front();
          if (result_value_o !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, result_value_o);
            n_fail++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        n_taken++;
        if (func_i) begin
          want = pin_on ? pin_answer : predict_lookup(key_x_i);
          answers_due.insert(answers_due.size(), want);
        end else begin
          if (restart_i) pt_count = 0;
          if (pt_count < TBL_DEPTH) begin
            pt_x[pt_count] = key_x_i;
            pt_y[pt_count] = point_value_i;
            pt_count++;
          end
        end
      end
      if (done_o || (start && !busy)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [31:0] rand_abscissa(bit coarse);
    if (!coarse) return $urandom;
    if ($urandom_range(0, 3) == 0) begin
      return {16'($urandom_range(0, 40) - 20), 16'($urandom_range(0, 65535))};
    end
    return {16'($urandom_range(0, 40) - 20), 16'h0000};
  endfunction

  function automatic logic [31:0] rand_ordinate();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return 32'($urandom_range(0, 400) - 200) <<< 16;
  endfunction

  function automatic logic [31:0] pick_probe(bit coarse);
    int r;
    logic [31:0] hit;
    r = $urandom_range(0, 9);
    hit = (pt_count > 0) ? pt_x[$urandom_range(0, pt_count - 1)] : $urandom;
    case (r)
      0, 1, 2: return hit;
      3: return hit + 32'd1;
      4: return hit - 32'd1;
      5: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: begin
        if (coarse) return {16'($urandom_range(0, 44) - 22), 16'($urandom_range(0, 65535))};
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_request(input step_t s, input int gap);
    int seen;
    seen = n_taken;
    start <= 1'b1;
    func_i <= s.is_query;
    restart_i <= s.clear;
    key_x_i <= s.x;
    point_value_i <= s.y;
    pin_on <= s.pinned;
    pin_answer <= s.want;
    do @(negedge clk_i); while (n_taken == seen);
    n_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random(input logic q, input logic r, input logic [31:0] x,
                             input logic [31:0] y, input int gap);
    step_t s;
    s = '{is_query: q, clear: r, x: x, y: y, pinned: 1'b0, want: '0};
    send_request(s, gap);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    step_t plan [PLAN_ROWS];
    bit burst;
    bit coarse;
    int n_pts;
    int n_q;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = 1'b0;
    restart_i = 1'b0;
    key_x_i = '0;
    point_value_i = '0;
    pin_on = 1'b0;
    pin_answer = '0;
    pt_count = 0;
    n_taken = 0;
    n_sent = 0;
    n_fail = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    plan[0]  = '{1'b1, 1'b1, 32'h0000_0000, 32'hffff_ffff, 1'b1, '{32'h0, tli_pkg::ST_EMPTY}};
    plan[1]  = '{1'b0, 1'b1, 32'h0000_0000, 32'd100, 1'b0, '0};
    plan[2]  = '{1'b1, 1'b0, 32'h0000_0000, 32'h0, 1'b1, '{32'd100, tli_pkg::ST_EXACT}};
    plan[3]  = '{1'b1, 1'b0, 32'hffff_ffff, 32'h0, 1'b1, '{32'h0, tli_pkg::ST_BELOW}};
    plan[4]  = '{1'b1, 1'b1, 32'h0000_0001, 32'h7fff_ffff, 1'b1, '{32'h0, tli_pkg::ST_ABOVE}};
    plan[5]  = '{1'b0, 1'b0, 32'h0001_0000, 32'h0002_0000, 1'b0, '0};
    plan[6]  = '{1'b1, 1'b0, 32'h0000_8000, 32'h0, 1'b0, '0};
    plan[7]  = '{1'b0, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 1'b0, '0};
    plan[8]  = '{1'b0, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '0};
    plan[9]  = '{1'b1, 1'b0, 32'h8000_0000, 32'h0, 1'b1, '{32'h7fff_ffff, tli_pkg::ST_EXACT}};
    plan[10] = '{1'b1, 1'b0, 32'h7fff_ffff, 32'h0, 1'b1, '{32'h8000_0000, tli_pkg::ST_EXACT}};
    plan[11] = '{1'b1, 1'b0, 32'hffff_ffff, 32'h0, 1'b0, '0};
    plan[12] = '{1'b1, 1'b0, 32'h4000_0000, 32'h0, 1'b0, '0};
    plan[13] = '{1'b0, 1'b0, 32'h0000_0000, 32'd555, 1'b0, '0};
    plan[14] = '{1'b1, 1'b0, 32'h0000_0000, 32'h0, 1'b1, '{32'd100, tli_pkg::ST_EXACT}};
    plan[15] = '{1'b0, 1'b1, 32'd5, 32'hffff_fff9, 1'b0, '0};
    plan[16] = '{1'b1, 1'b0, 32'd5, 32'h0, 1'b1, '{32'hffff_fff9, tli_pkg::ST_EXACT}};
    plan[17] = '{1'b1, 1'b0, 32'd4, 32'h0, 1'b1, '{32'h0, tli_pkg::ST_BELOW}};
    plan[18] = '{1'b1, 1'b0, 32'd6, 32'h0, 1'b1, '{32'h0, tli_pkg::ST_ABOVE}};
    plan[19] = '{1'b0, 1'b0, 32'd5, 32'd999, 1'b0, '0};
    plan[20] = '{1'b0, 1'b0, 32'd15, 32'hffff_ffe5, 1'b0, '0};
    plan[21] = '{1'b1, 1'b0, 32'd7, 32'h0, 1'b0, '0};
    plan[22] = '{1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0, '0};
    plan[23] = '{1'b0, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0};
    plan[24] = '{1'b1, 1'b0, 32'h0000_0000, 32'h0, 1'b0, '0};
    plan[25] = '{1'b1, 1'b1, 32'h1234_5678, 32'hffff_ffff, 1'b0, '0};
    foreach (plan[i]) send_request(plan[i], pick_gap(1'b0));

    // fill past capacity, then probe the full table
    send_random(1'b0, 1'b1, $urandom, $urandom, 0);
    for (int i = 0; i < TBL_DEPTH + 3; i++) begin
      send_random(1'b0, 1'b0, $urandom, $urandom, pick_gap(1'b1));
    end
    for (int i = 0; i < 12; i++) begin
      send_random(1'b1, 1'($urandom), pick_probe(1'b0), $urandom, pick_gap(1'b0));
    end
    drain();
    send_random(1'b0, 1'b1, 32'h0003_0000, 32'hdead_beef, 0);
    send_random(1'b1, 1'b0, 32'h0003_0000, $urandom, pick_gap(1'b0));

    while (n_sent < ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      coarse = $urandom_range(0, 1);
      n_pts = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      n_q = $urandom_range(1, 10);
      for (int i = 0; i < n_pts; i++) begin
        send_random(1'b0,
                    (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 19) == 0),
                    rand_abscissa(coarse), rand_ordinate(), pick_gap(burst));
      end
      for (int i = 0; i < n_q; i++) begin
        send_random(1'b1, 1'($urandom), pick_probe(coarse), $urandom, pick_gap(burst));
      end
      if ($urandom_range(0, 4) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
